FILE: sv/sfop_pkg.sv
// ----------------------------------------------------------------------------
// sfop_pkg
// Types, register indexes and reset values for the spectral flux onset picker.
// ----------------------------------------------------------------------------
package sfop_pkg;

    localparam int unsigned BAND_W  = 24;
    localparam int unsigned FLUX_W  = 32;
    localparam int unsigned DECAY_W = 16;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_DECAY      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_LENGTH     = 3'd5;

    // register reset values
    localparam logic [FLUX_W-1:0]  RST_UPPER_THRESHOLD = 32'd32768;
    localparam logic [FLUX_W-1:0]  RST_LOWER_THRESHOLD = 32'd6554;
    localparam logic [COUNT_W-1:0] RST_DEBOUNCE_LIMIT  = 8'd0;
    localparam logic [COUNT_W-1:0] RST_HOLDOFF_LIMIT   = 8'd10;
    localparam logic [DECAY_W-1:0] RST_MASK_DECAY      = 16'd45875;
    localparam logic [COUNT_W-1:0] RST_MASK_LENGTH     = 8'd4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [FLUX_W-1:0]  FLUX_MAX  = {FLUX_W{1'b1}};

    typedef struct packed {
        logic signed [BAND_W-1:0] current_band;
        logic signed [BAND_W-1:0] previous_band;
        logic                     last_band;
    } t_in_item;

    typedef struct packed {
        logic              onset;
        logic [FLUX_W-1:0] peak_level;
        logic [FLUX_W-1:0] frame_flux;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECAY,
        S_PICK
    } t_state;

    // two's complement magnitude; the most negative code maps onto itself
    function automatic logic [BAND_W-1:0] band_mag(input logic [BAND_W-1:0] v);
        return v[BAND_W-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

FILE: sv/spectral_flux_onset_picker.sv
// ----------------------------------------------------------------------------
// spectral_flux_onset_picker
// Spectral flux accumulator with masking decay, holdoff and hysteresis picker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one band pair
//   per request. A request is taken at a clock edge with valid high and stall
//   low. Requests without last_band are added to the sum without a stall.
//   The request with last_band closes the frame: its sum is latched, then
//   (mask_length - mask_count) decay steps run on one shared 32x16
//   multiplier while masking is active, then holdoff and peak picking run
//   in the pick step. The input stalls meanwhile.
//   Output channel (o_out_valid / i_out_stall / o_out_data) carries one result
//   per frame from an output register. New bands are taken while a result
//   waits; a further frame end waits in the pick step until the register frees.
//   Configuration (i_cfg_we / i_cfg_index / i_cfg_data) must be written
//   while idle; the block does not enforce it. Unknown indexes are ignored.
//   Reset (synchronous, active low) clears the tracking state but for the
//   datapath, restores the register defaults; no result is pending afterwards.
// ----------------------------------------------------------------------------
module spectral_flux_onset_picker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  sfop_pkg::t_in_item                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output sfop_pkg::t_out_item                    o_out_data,
    input  logic                                   i_cfg_we,
    input  logic [sfop_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sfop_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import sfop_pkg::*;

    // configuration
    logic [FLUX_W-1:0]  r_upper_thr;
    logic [FLUX_W-1:0]  r_lower_thr;
    logic [COUNT_W-1:0] r_debounce_lim;
    logic [COUNT_W-1:0] r_holdoff_lim;
    logic [DECAY_W-1:0] r_mask_decay;
    logic [COUNT_W-1:0] r_mask_len;

    // tracking state
    t_state             r_state,        n_state;
    logic [FLUX_W-1:0]  r_flux_sum,     n_flux_sum;
    logic [FLUX_W-1:0]  r_flux,         n_flux;
    logic [COUNT_W-1:0] r_steps,        n_steps;
    logic               r_armed,        n_armed;
    logic [COUNT_W-1:0] r_debounce_cnt, n_debounce_cnt;
    logic [FLUX_W-1:0]  r_held_peak,    n_held_peak;
    logic               r_hold_act,     n_hold_act;
    logic [COUNT_W-1:0] r_hold_cnt,     n_hold_cnt;
    logic               r_mask_act,     n_mask_act;
    logic [COUNT_W-1:0] r_mask_cnt,     n_mask_cnt;
    logic               r_out_valid,    n_out_valid;
    t_out_item          r_out_data,     n_out_data;

    logic                     in_take;
    logic [BAND_W-1:0]        cur_mag;
    logic [BAND_W-1:0]        prev_mag;
    logic [BAND_W-1:0]        rise;
    logic [FLUX_W:0]          acc_wide;
    logic [FLUX_W-1:0]        acc_sat;
    logic [FLUX_W+DECAY_W-1:0] product;
    logic                     pick_go;
    logic                     hold_tmp;
    logic                     onset;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // positive part of the magnitude rise, saturating sum
    assign cur_mag  = band_mag(i_in_data.current_band);
    assign prev_mag = band_mag(i_in_data.previous_band);
    assign rise     = (cur_mag > prev_mag) ? (cur_mag - prev_mag) : '0;
    assign acc_wide = {1'b0, r_flux_sum} + {{(FLUX_W + 1 - BAND_W){1'b0}}, rise};
    assign acc_sat  = acc_wide[FLUX_W] ? FLUX_MAX : acc_wide[FLUX_W-1:0];

    // shared decay multiplier: flux * Q0.16 decay, floor
    assign product = r_flux * r_mask_decay;

    // pick step may retire once the output register is free or draining
    assign pick_go = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_thr    <= RST_UPPER_THRESHOLD;
            r_lower_thr    <= RST_LOWER_THRESHOLD;
            r_debounce_lim <= RST_DEBOUNCE_LIMIT;
            r_holdoff_lim  <= RST_HOLDOFF_LIMIT;
            r_mask_decay   <= RST_MASK_DECAY;
            r_mask_len     <= RST_MASK_LENGTH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_UPPER_THRESHOLD: r_upper_thr    <= i_cfg_data;
                REG_LOWER_THRESHOLD: r_lower_thr    <= i_cfg_data;
                REG_DEBOUNCE_LIMIT:  r_debounce_lim <= i_cfg_data[COUNT_W-1:0];
                REG_HOLDOFF_LIMIT:   r_holdoff_lim  <= i_cfg_data[COUNT_W-1:0];
                REG_MASK_DECAY:      r_mask_decay   <= i_cfg_data[DECAY_W-1:0];
                REG_MASK_LENGTH:     r_mask_len     <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_flux_sum     <= '0;
            r_armed        <= 1'b0;
            r_debounce_cnt <= '0;
            r_held_peak    <= '0;
            r_hold_act     <= 1'b0;
            r_hold_cnt     <= '0;
            r_mask_act     <= 1'b0;
            r_mask_cnt     <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_flux_sum     <= n_flux_sum;
            r_armed        <= n_armed;
            r_debounce_cnt <= n_debounce_cnt;
            r_held_peak    <= n_held_peak;
            r_hold_act     <= n_hold_act;
            r_hold_cnt     <= n_hold_cnt;
            r_mask_act     <= n_mask_act;
            r_mask_cnt     <= n_mask_cnt;
            r_out_valid    <= n_out_valid;
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        r_flux     <= n_flux;
        r_steps    <= n_steps;
        r_out_data <= n_out_data;
    end

    always_comb begin
        n_state        = r_state;
        n_flux_sum     = r_flux_sum;
        n_flux         = r_flux;
        n_steps        = r_steps;
        n_armed        = r_armed;
        n_debounce_cnt = r_debounce_cnt;
        n_held_peak    = r_held_peak;
        n_hold_act     = r_hold_act;
        n_hold_cnt     = r_hold_cnt;
        n_mask_act     = r_mask_act;
        n_mask_cnt     = r_mask_cnt;
        n_out_valid    = r_out_valid && i_out_stall;
        n_out_data     = r_out_data;
        hold_tmp       = r_hold_act;
        onset          = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    if (!i_in_data.last_band) begin
                        n_flux_sum = acc_sat;
                    end else begin
                        n_flux_sum = '0;
                        n_flux     = acc_sat;
                        n_state    = S_PICK;
                        // mask release or schedule the decay run
                        if (r_mask_act) begin
                            if (r_mask_cnt >= r_mask_len) begin
                                n_mask_act = 1'b0;
                                n_mask_cnt = '0;
                            end else begin
                                n_steps    = r_mask_len - r_mask_cnt;
                                n_mask_cnt = r_mask_cnt + 1'b1;
                                n_state    = S_DECAY;
                            end
                        end
                    end
                end
            end

            S_DECAY: begin
                n_flux  = product[FLUX_W+DECAY_W-1:DECAY_W];
                n_steps = r_steps - 1'b1;
                if (r_steps == {{(COUNT_W-1){1'b0}}, 1'b1}) begin
                    n_state = S_PICK;
                end
            end

            S_PICK: begin
                if (pick_go) begin
                    // holdoff advance
                    n_hold_cnt = r_hold_cnt;
                    if (r_hold_act) begin
                        if (r_hold_cnt > r_holdoff_lim) begin
                            hold_tmp   = 1'b0;
                            n_hold_cnt = '0;
                        end else if (r_hold_cnt < COUNT_MAX) begin
                            n_hold_cnt = r_hold_cnt + 1'b1;
                        end
                    end
                    n_hold_act = hold_tmp;

                    // hysteresis picker, suppressed during holdoff
                    if (!r_armed) begin
                        if (r_flux > r_upper_thr && !hold_tmp) begin
                            n_armed        = 1'b1;
                            n_debounce_cnt = {{(COUNT_W-1){1'b0}}, 1'b1};
                            n_held_peak    = r_flux;
                        end
                    end else if (r_flux > r_held_peak) begin
                        if (!hold_tmp) begin
                            n_debounce_cnt = {{(COUNT_W-1){1'b0}}, 1'b1};
                            n_held_peak    = r_flux;
                        end
                    end else if (r_debounce_cnt > r_debounce_lim
                                 || r_flux < r_lower_thr) begin
                        if (!hold_tmp) begin
                            onset = 1'b1;
                        end
                    end else if (r_debounce_cnt < COUNT_MAX) begin
                        n_debounce_cnt = r_debounce_cnt + 1'b1;
                    end

                    if (onset) begin
                        n_debounce_cnt = '0;
                        n_armed        = 1'b0;
                        n_hold_act     = 1'b1;
                        n_mask_act     = 1'b1;
                    end

                    n_out_valid           = 1'b1;
                    n_out_data.onset      = onset;
                    n_out_data.peak_level = n_held_peak;
                    n_out_data.frame_flux = r_flux;
                    n_state               = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
